### design/utse_pkg.sv
package utse_pkg;

  localparam int unsigned TS_LEN  = 24;
  localparam int unsigned POS_SAT = 25;

  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_T     = 8'h54;  // 'T'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_Z     = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam int unsigned HOUR_MAX  = 23;
  localparam int unsigned MIN_MAX   = 59;
  localparam int unsigned SEC_MAX   = 59;
  localparam int unsigned MILLI_MAX = 999;

  // floor(x * RECIP25 / 2^17) equals floor(x / 25) for every x below 16384.
  localparam int unsigned RECIP25 = 5243;

  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam int unsigned YEAR_DAYS    = 365;
  localparam int unsigned YEAR_OFFSET  = 400;
  // Days from 0000-03-01 (shifted by one 400-year era) to the epoch, plus one
  // for the one-based day of month.
  localparam int unsigned DAY_BIAS = 719468 + 146097 + 1;

  localparam int unsigned EPOCH_W = 49;
  localparam int unsigned SECS_W  = 39;
  localparam int unsigned DAYS_W  = 24;

  typedef struct packed {
    logic take;    // a character beat is accepted
    logic ld1;     // snapshot the fields and clear the accumulators
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
    logic ld_out;  // write the result register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // Days before the month in a year that starts on March 1st.
  function automatic logic [8:0] month_base(input logic [3:0] mo);
    logic [8:0] r;
    unique case (mo)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] r;
    unique case (mo)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

### design/utc_timestamp_to_epoch_millis_unit.sv
// Takes one character beat per cycle while collecting a timestamp string.
// After the beat with tlast, a six-step sequencer computes the epoch time;
// the result beat becomes valid when the last step loads the result register,
// which waits while the output stalls. The input side is free again as
// soon as the result is loaded, even while that result waits to be taken.
// Reset (rst_ni, asynchronous, active low) empties the output and clears the collector.
module utc_timestamp_to_epoch_millis_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [48:0] epoch_ms, [55:49] zero
  output logic        m_axis_tuser    // [0] valid_res
);
  import utse_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [48:0] ms;

  utse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s_axis_tvalid),
    .in_last_i (s_axis_tlast),
    .in_rdy_o  (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  utse_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .char_i    (s_axis_tdata),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .out_ok_o  (m_axis_tuser),
    .out_ms_o  (ms)
  );

  assign m_axis_tdata = {7'd0, ms};

endmodule

### design/utse_datapath.sv
module utse_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utse_pkg::cmd_t      cmd_i,
  output utse_pkg::sts_t      sts_o,
  input  logic [7:0]          char_i,
  output logic                out_vld_o,
  input  logic                out_rdy_i,
  output logic                out_ok_o,
  output logic [48:0]         out_ms_o
);
  import utse_pkg::*;

  // Character accumulators.
  logic [4:0]  pos_q, pos_d;
  logic        bad_q, bad_d;
  logic [13:0] yr_q, yr_d;
  logic [6:0]  mo_q, mo_d, dy_q, dy_d, hr_q, hr_d, mi_q, mi_d, sc_q, sc_d;
  logic [9:0]  ml_q, ml_d;

  // Epoch computation stages.
  logic [13:0] ysh_q, yraw_q;
  logic [8:0]  y25_q;
  logic [9:0]  doy_q;
  logic [16:0] hms_q;
  logic        rng_ok_q;
  logic [3:0]  mo_s_q;
  logic [6:0]  dy_s_q;
  logic [9:0]  ml_s_q;
  logic        leap_q;
  logic [6:0]  cent_q;
  logic [4:0]  quad_q;
  logic [21:0] ydays_q;
  logic        ok_q;
  logic [DAYS_W-1:0] days_q;
  logic signed [SECS_W-1:0] dsec_q, secs_q;

  logic        out_vld_q;
  logic        out_ok_q;
  logic [48:0] out_ms_q;

  function automatic logic [13:0] acc10(input logic [13:0] v, input logic [3:0] d);
    return 14'((v << 3) + (v << 1) + {10'd0, d});
  endfunction

  logic        sep_hit;
  logic [7:0]  sep_chr;
  logic        is_digit;
  logic [3:0]  digit;
  logic        examine;

  always_comb begin
    sep_hit = 1'b1;
    sep_chr = CH_DASH;
    unique case (pos_q)
      5'd4, 5'd7:   sep_chr = CH_DASH;
      5'd10:        sep_chr = CH_T;
      5'd13, 5'd16: sep_chr = CH_COLON;
      5'd19:        sep_chr = CH_DOT;
      5'd23:        sep_chr = CH_Z;
      default:      sep_hit = 1'b0;
    endcase
  end

  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign digit    = 4'(char_i - CH_ZERO);
  assign examine  = cmd_i.take && (pos_q < 5'(TS_LEN));

  always_comb begin
    pos_d = pos_q;
    bad_d = bad_q;
    yr_d  = yr_q;
    mo_d  = mo_q;
    dy_d  = dy_q;
    hr_d  = hr_q;
    mi_d  = mi_q;
    sc_d  = sc_q;
    ml_d  = ml_q;
    if (cmd_i.ld1) begin
      pos_d = '0;
      bad_d = 1'b0;
      yr_d  = '0;
      mo_d  = '0;
      dy_d  = '0;
      hr_d  = '0;
      mi_d  = '0;
      sc_d  = '0;
      ml_d  = '0;
    end else if (cmd_i.take) begin
      if (pos_q < 5'(POS_SAT)) begin
        pos_d = pos_q + 5'd1;
      end
      if (examine) begin
        priority if (sep_hit) begin
          if (char_i != sep_chr) bad_d = 1'b1;
        end else if (!is_digit) begin
          bad_d = 1'b1;
        end else if (pos_q < 5'd4) begin
          yr_d = acc10(yr_q, digit);
        end else if (pos_q < 5'd7) begin
          mo_d = 7'(acc10({7'd0, mo_q}, digit));
        end else if (pos_q < 5'd10) begin
          dy_d = 7'(acc10({7'd0, dy_q}, digit));
        end else if (pos_q < 5'd13) begin
          hr_d = 7'(acc10({7'd0, hr_q}, digit));
        end else if (pos_q < 5'd16) begin
          mi_d = 7'(acc10({7'd0, mi_q}, digit));
        end else if (pos_q < 5'd19) begin
          sc_d = 7'(acc10({7'd0, sc_q}, digit));
        end else begin
          ml_d = 10'(acc10({4'd0, ml_q}, digit));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      bad_q <= 1'b0;
      yr_q  <= '0;
      mo_q  <= '0;
      dy_q  <= '0;
      hr_q  <= '0;
      mi_q  <= '0;
      sc_q  <= '0;
      ml_q  <= '0;
    end else begin
      pos_q <= pos_d;
      bad_q <= bad_d;
      yr_q  <= yr_d;
      mo_q  <= mo_d;
      dy_q  <= dy_d;
      hr_q  <= hr_d;
      mi_q  <= mi_d;
      sc_q  <= sc_d;
      ml_q  <= ml_d;
    end
  end

  // Stage 1: snapshot, range checks, shifted year, year / 25.
  logic [26:0] y25_prod;
  logic        rng_ok_d;
  assign y25_prod = 27'(yr_q) * 27'(RECIP25);
  assign rng_ok_d = (pos_q == 5'(TS_LEN)) && !bad_q &&
                    (hr_q <= 7'(HOUR_MAX)) && (mi_q <= 7'(MIN_MAX)) &&
                    (sc_q <= 7'(SEC_MAX)) && (ml_q <= 10'(MILLI_MAX)) &&
                    (mo_q >= 7'd1) && (mo_q <= 7'd12) && (dy_q >= 7'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld1) begin
      yraw_q   <= yr_q;
      ysh_q    <= 14'(yr_q + 14'(YEAR_OFFSET) - ((mo_q <= 7'd2) ? 14'd1 : 14'd0));
      y25_q    <= y25_prod[25:17];
      doy_q    <= 10'(month_base(mo_q[3:0])) + 10'(dy_q);
      hms_q    <= 17'(19'(hr_q) * 19'(SEC_PER_HOUR) + 19'(mi_q) * 19'(SEC_PER_MIN) +
                      19'(sc_q));
      rng_ok_q <= rng_ok_d;
      mo_s_q   <= mo_q[3:0];
      dy_s_q   <= dy_q;
      ml_s_q   <= ml_q;
    end
  end

  // Stage 2: leap year, century and 400-year counts, 365 * year.
  logic [13:0] r25;
  logic [24:0] cent_prod, quad_prod;
  logic        yz25;
  assign r25       = 14'(yraw_q - 14'(y25_q) * 14'd25);
  assign yz25      = (r25 == 14'd0);
  assign cent_prod = 25'(ysh_q[13:2]) * 25'(RECIP25);
  assign quad_prod = 25'(ysh_q[13:4]) * 25'(RECIP25);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld2) begin
      leap_q  <= ((yraw_q[1:0] == 2'd0) && !yz25) || ((yraw_q[3:0] == 4'd0) && yz25);
      cent_q  <= cent_prod[23:17];
      quad_q  <= quad_prod[21:17];
      ydays_q <= 22'(ysh_q) * 22'(YEAR_DAYS);
    end
  end

  // Stage 3: day count from the epoch and the day-of-month check.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld3) begin
      days_q <= DAYS_W'(ydays_q) + DAYS_W'(ysh_q[13:2]) - DAYS_W'(cent_q) +
                DAYS_W'(quad_q) + DAYS_W'(doy_q) - DAYS_W'(DAY_BIAS);
      ok_q   <= rng_ok_q && (dy_s_q <= {2'd0, month_days(mo_s_q, leap_q)});
    end
  end

  // Stage 4: days to seconds.
  logic signed [41:0] dsec_prod;
  assign dsec_prod = $signed(days_q) * $signed(18'(SEC_PER_DAY));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld4) begin
      dsec_q <= dsec_prod[SECS_W-1:0];
    end
  end

  // Stage 5: add the time of day.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld5) begin
      secs_q <= dsec_q + $signed({22'd0, hms_q});
    end
  end

  // Stage 6: seconds * 1000 as 1024 - 16 - 8, plus the milliseconds.
  logic [EPOCH_W-1:0] s49, ms_val;
  assign s49    = {{(EPOCH_W - SECS_W){secs_q[SECS_W-1]}}, secs_q};
  assign ms_val = (s49 << 10) - (s49 << 4) - (s49 << 3) + EPOCH_W'(ml_s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.ld_out) begin
      out_vld_q <= 1'b1;
    end else if (out_rdy_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      out_ok_q <= ok_q;
      out_ms_q <= ok_q ? ms_val : '0;
    end
  end

  assign sts_o.out_free = !out_vld_q || out_rdy_i;
  assign out_vld_o      = out_vld_q;
  assign out_ok_o       = out_ok_q;
  assign out_ms_o       = out_ms_q;

`ifndef SYNTHESIS
  a_clear_on_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld1 |=> (pos_q == 5'd0) && !bad_q)
    else $error("accumulators not cleared after snapshot");
  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ok_q |-> out_ms_q == '0)
    else $error("invalid result carries a nonzero time");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_out |=> out_vld_q)
    else $error("result load did not raise valid");
`endif

endmodule

### design/utse_ctrl.sv
module utse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_vld_i,
  input  logic           in_last_i,
  output logic           in_rdy_o,
  input  utse_pkg::sts_t sts_i,
  output utse_pkg::cmd_t cmd_o
);
  import utse_pkg::*;

  localparam logic [2:0] COLLECT = 3'd0;
  localparam logic [2:0] CALC1   = 3'd1;
  localparam logic [2:0] CALC2   = 3'd2;
  localparam logic [2:0] CALC3   = 3'd3;
  localparam logic [2:0] CALC4   = 3'd4;
  localparam logic [2:0] CALC5   = 3'd5;
  localparam logic [2:0] CALC6   = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_rdy_o = (state_q == COLLECT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      COLLECT: begin
        cmd_o.take = in_vld_i;
        if (in_vld_i && in_last_i) state_d = CALC1;
      end
      CALC1: begin
        cmd_o.ld1 = 1'b1;
        state_d   = CALC2;
      end
      CALC2: begin
        cmd_o.ld2 = 1'b1;
        state_d   = CALC3;
      end
      CALC3: begin
        cmd_o.ld3 = 1'b1;
        state_d   = CALC4;
      end
      CALC4: begin
        cmd_o.ld4 = 1'b1;
        state_d   = CALC5;
      end
      CALC5: begin
        cmd_o.ld5 = 1'b1;
        state_d   = CALC6;
      end
      CALC6: begin
        // Wait here until the result register can take the new beat.
        if (sts_i.out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = COLLECT;
        end
      end
      default: state_d = COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> sts_i.out_free)
    else $error("result loaded over a pending beat");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CALC6) && !sts_i.out_free |=> state_q == CALC6)
    else $error("left final step while output stalled");
  a_last_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take && in_last_i |=> state_q == CALC1)
    else $error("last character did not start the computation");
`endif

endmodule

### bench/ts_epoch_checker.sv
module ts_epoch_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] char_code
  input  logic        s_tlast_i,   // last_char
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,   // [48:0] epoch_ms, [55:49] zero
  input  logic        m_tuser_i,   // [0] valid_res
  output int          fails_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import utse_pkg::*;

  typedef struct packed {
    logic [4:0]  pos;
    logic        bad;
    logic [13:0] yr;
    logic [6:0]  mo;
    logic [6:0]  dy;
    logic [6:0]  hr;
    logic [6:0]  mi;
    logic [6:0]  se;
    logic [9:0]  ms;
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    logic [48:0] epoch;
  } stamp_t;

  parse_state_t parse_st;
  stamp_t       expected_stamps[$];
  int           mismatches = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic parse_state_t parse_char(input parse_state_t cur, input logic [7:0] ch);
    parse_state_t n;
    logic [7:0]   sep;
    logic [3:0]   dg;
    n   = cur;
    sep = 8'h00;
    if (cur.pos < TS_LEN) begin
      case (cur.pos)
        5'd4, 5'd7:   sep = CH_DASH;
        5'd10:        sep = CH_T;
        5'd13, 5'd16: sep = CH_COLON;
        5'd19:        sep = CH_DOT;
        5'd23:        sep = CH_Z;
        default:      sep = 8'h00;
      endcase
      if (sep != 8'h00) begin
        if (ch != sep) n.bad = 1'b1;
      end else if (ch < CH_ZERO || ch > CH_NINE) begin
        n.bad = 1'b1;
      end else begin
        dg = 4'(ch - CH_ZERO);
        // Accumulators wrap at their register widths.
        if (cur.pos < 4)       n.yr = cur.yr * 14'd10 + 14'(dg);
        else if (cur.pos < 7)  n.mo = cur.mo * 7'd10 + 7'(dg);
        else if (cur.pos < 10) n.dy = cur.dy * 7'd10 + 7'(dg);
        else if (cur.pos < 13) n.hr = cur.hr * 7'd10 + 7'(dg);
        else if (cur.pos < 16) n.mi = cur.mi * 7'd10 + 7'(dg);
        else if (cur.pos < 19) n.se = cur.se * 7'd10 + 7'(dg);
        else                   n.ms = cur.ms * 10'd10 + 10'(dg);
      end
    end
    if (cur.pos < POS_SAT) n.pos = cur.pos + 5'd1;
    return n;
  endfunction

  function automatic int days_of_month(input logic [13:0] yr, input logic [6:0] mo);
    int  y;
    bit  leap;
    y    = int'(yr);
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (mo == 7'd2) return leap ? 29 : 28;
    if (mo == 7'd4 || mo == 7'd6 || mo == 7'd9 || mo == 7'd11) return 30;
    return 31;
  endfunction

  function automatic stamp_t finish_stamp(input parse_state_t s);
    stamp_t r;
    longint y, era, yoe, mp, doy, doe, days, secs, total;
    logic   ok;
    ok = (s.pos == TS_LEN) && !s.bad && (s.hr <= HOUR_MAX) && (s.mi <= MIN_MAX) &&
         (s.se <= SEC_MAX) && (s.ms <= MILLI_MAX) && (s.mo >= 7'd1) && (s.mo <= 7'd12) &&
         (s.dy >= 7'd1) && (int'(s.dy) <= days_of_month(s.yr, s.mo));
    total = 0;
    if (ok) begin
      // Count from March 1st so that the leap day falls at the end of a year.
      y     = longint'(s.yr) - ((s.mo <= 7'd2) ? 1 : 0);
      era   = ((y >= 0) ? y : y - 399) / 400;
      yoe   = y - era * 400;
      mp    = (longint'(s.mo) + 9) % 12;
      doy   = (153 * mp + 2) / 5 + longint'(s.dy) - 1;
      doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days  = era * 146097 + doe - 719468;
      secs  = days * 86400 + longint'(s.hr) * 3600 + longint'(s.mi) * 60 + longint'(s.se);
      total = secs * 1000 + longint'(s.ms);
    end
    r.ok    = ok;
    r.epoch = total[48:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    stamp_t want;
    if (!rst_ni) begin
      parse_st = '0;
      expected_stamps.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_stamps.size() == 0) begin
          report_mismatch("result beat with nothing expected", 64'(m_tdata_i), 64'd0);
        end else begin
          want = expected_stamps.pop_front();
          if (m_tuser_i !== want.ok)
            report_mismatch("valid_res", 64'(m_tuser_i), 64'(want.ok));
          if (m_tdata_i[48:0] !== want.epoch)
            report_mismatch("epoch_ms", 64'(m_tdata_i[48:0]), 64'(want.epoch));
          if (m_tdata_i[55:49] !== 7'd0)
            report_mismatch("tdata padding", 64'(m_tdata_i[55:49]), 64'd0);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        parse_st = parse_char(parse_st, s_tdata_i);
        if (s_tlast_i) begin
          expected_stamps.push_back(finish_stamp(parse_st));
          parse_st = '0;
        end
      end
    end
    pending_o <= expected_stamps.size();
    fails_o   <= mismatches;
  end

endmodule

### bench/utc_timestamp_to_epoch_millis_unit_tb.sv
module utc_timestamp_to_epoch_millis_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import utse_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int BEAT_TARGET = 1950;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;

  int         fail_count;
  int         pending_count;
  int         beats_sent  = 0;
  int         idle_cycles = 0;
  bit         tx_gaps     = 1'b1;
  bit         rx_gaps     = 1'b1;
  bit         hold_req    = 1'b0;
  logic [7:0] line_q[$];

  always #2 clk_i = ~clk_i;

  utc_timestamp_to_epoch_millis_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  ts_epoch_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .fails_o    (fail_count),
    .pending_o  (pending_count)
  );

  task automatic put_num(input int v, input int digits);
    int div;
    div = 1;
    repeat (digits - 1) div *= 10;
    repeat (digits) begin
      line_q.push_back(CH_ZERO + 8'((v / div) % 10));
      div /= 10;
    end
  endtask

  task automatic build_stamp(input int y, input int mo, input int d, input int h,
                             input int mi, input int s, input int ms);
    line_q.delete();
    put_num(y, 4);
    line_q.push_back(CH_DASH);
    put_num(mo, 2);
    line_q.push_back(CH_DASH);
    put_num(d, 2);
    line_q.push_back(CH_T);
    put_num(h, 2);
    line_q.push_back(CH_COLON);
    put_num(mi, 2);
    line_q.push_back(CH_COLON);
    put_num(s, 2);
    line_q.push_back(CH_DOT);
    put_num(ms, 3);
    line_q.push_back(CH_Z);
  endtask

  task automatic rand_stamp();
    int y, mo, d, h, mi, s, ms;
    case ($urandom_range(0, 7))
      0:       y = 0;
      1:       y = 9999;
      2:       y = 1969 + $urandom_range(0, 1);
      3:       y = 100 * $urandom_range(0, 99);
      default: y = $urandom_range(0, 9999);
    endcase
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0:       d = $urandom_range(0, 99);
      1, 2:    d = $urandom_range(28, 31);
      default: d = $urandom_range(1, 28);
    endcase
    h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    s  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    ms = $urandom_range(0, 999);
    build_stamp(y, mo, d, h, mi, s, ms);
  endtask

  task automatic send_line();
    int gap;
    for (int i = 0; i < line_q.size(); i++) begin
      gap = tx_gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= line_q[i];
      s_tlast  <= (i == line_q.size() - 1);
      @(posedge clk_i);
      while (!s_tready) @(posedge clk_i);
      beats_sent++;
    end
  endtask

  // The first edge lets the checker record the final beat of the last line.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    int kind;
    int n;
    int strings;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_stamp(1970, 1, 1, 0, 0, 0, 0);     send_line();
    build_stamp(0, 1, 1, 0, 0, 0, 0);        send_line();
    build_stamp(9999, 12, 31, 23, 59, 59, 999); send_line();
    build_stamp(1969, 12, 31, 23, 59, 59, 999); send_line();
    build_stamp(2000, 2, 29, 12, 30, 45, 500);  send_line();
    build_stamp(1900, 2, 29, 0, 0, 0, 0);    send_line();
    build_stamp(2023, 2, 29, 0, 0, 0, 0);    send_line();
    build_stamp(2024, 4, 31, 0, 0, 0, 0);    send_line();
    build_stamp(2024, 0, 10, 0, 0, 0, 0);    send_line();
    build_stamp(2024, 13, 10, 0, 0, 0, 0);   send_line();
    build_stamp(2024, 5, 0, 0, 0, 0, 0);     send_line();
    build_stamp(2024, 5, 10, 24, 0, 0, 0);   send_line();
    build_stamp(2024, 5, 10, 0, 60, 0, 0);   send_line();
    build_stamp(2024, 5, 10, 0, 0, 60, 0);   send_line();
    build_stamp(99, 99, 99, 99, 99, 99, 999); send_line();
    // A sign where a digit belongs must not pass.
    build_stamp(2024, 5, 10, 1, 2, 3, 4);
    line_q[5] = CH_DASH;
    send_line();
    build_stamp(2024, 5, 10, 1, 2, 3, 4);
    line_q[10] = 8'h20;
    send_line();
    build_stamp(2024, 5, 10, 1, 2, 3, 4);
    line_q[12] = 8'hFF;
    line_q[0]  = 8'h00;
    send_line();
    build_stamp(2024, 5, 10, 1, 2, 3, 4);
    line_q[23] = 8'h7A;
    send_line();
    build_stamp(2024, 5, 10, 1, 2, 3, 4);
    while (line_q.size() > 23) void'(line_q.pop_back());
    send_line();
    line_q.delete();
    line_q.push_back(CH_ZERO);
    send_line();
    // Too long: bytes past the 24th are not examined, yet the line fails.
    build_stamp(2024, 5, 10, 1, 2, 3, 4);
    line_q.push_back(CH_Z);
    line_q.push_back(8'h00);
    send_line();
    drain();

    strings = 0;
    while (beats_sent < BEAT_TARGET) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      // Keep the input busy while the output is held off, so the block backs up.
      if (strings == 12) hold_req = 1'b1;
      if (strings >= 12 && strings < 20) tx_gaps = 1'b0;
      kind = $urandom_range(0, 99);
      rand_stamp();
      if (kind < 70) begin
      end else if (kind < 80) begin
        line_q[$urandom_range(0, 23)] = 8'($urandom_range(0, 255));
      end else if (kind < 87) begin
        n = $urandom_range(1, 23);
        while (line_q.size() > n) void'(line_q.pop_back());
      end else if (kind < 94) begin
        repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        line_q.delete();
        repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(0, 255)));
      end
      send_line();
      strings++;
      if (strings % 20 == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_gaps = !rx_gaps;
        gap = rx_gaps ? $urandom_range(0, 8) : 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
